[hw/rtl/vlrd_pkg.sv]
// Shared types, constants and pattern tables for the vocoder link response deframer.
package vlrd_pkg;

  localparam int unsigned AUDIO_PAYLOAD_BYTES_DEF = 320;
  localparam int unsigned VOICE_PAYLOAD_BYTES_DEF = 48;

  localparam int unsigned STSP_LEN = 5;
  localparam int unsigned NAME_LEN = 14;

  // header and resync bytes
  localparam logic [7:0] HDR_AUDIO_0 = 8'h42;
  localparam logic [7:0] HDR_AUDIO_1 = 8'h81;
  localparam logic [7:0] HDR_VOICE_0 = 8'h32;
  localparam logic [7:0] HDR_VOICE_1 = 8'hA0;
  localparam logic [7:0] HDR_STSP_0  = 8'h05;
  localparam logic [7:0] HDR_NAME_0  = 8'h0E;
  localparam logic [7:0] HDR_NOP_0   = 8'h02;
  localparam logic [7:0] HDR_ZERO_1  = 8'h00;
  localparam logic [7:0] STSP_START  = 8'h01;
  localparam logic [7:0] STSP_STOP   = 8'h00;

  typedef enum logic [2:0] {
    KIND_AUDIO   = 3'd0,
    KIND_VOICE   = 3'd1,
    KIND_START   = 3'd2,
    KIND_STOP    = 3'd3,
    KIND_NAME    = 3'd4,
    KIND_NOP     = 3'd5,
    KIND_UNKNOWN = 3'd6,
    KIND_ERROR   = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [8:0]  index;
    logic        last;
  } result_t;

  function automatic logic [7:0] stsp_pat(input logic [2:0] pos);
    logic [7:0] v;
    case (pos)
      3'd0:    v = 8'h05;
      3'd1:    v = 8'h00;
      3'd2:    v = 8'h18;
      3'd3:    v = 8'h00;
      3'd4:    v = 8'h01;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] name_pat(input logic [3:0] pos);
    logic [7:0] v;
    case (pos)
      4'd0:    v = 8'h0E;
      4'd1:    v = 8'h00;
      4'd2:    v = 8'h01;
      4'd3:    v = 8'h00;
      4'd4:    v = 8'h44;
      4'd5:    v = 8'h56;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h44;
      4'd8:    v = 8'h6F;
      4'd9:    v = 8'h6E;
      4'd10:   v = 8'h67;
      4'd11:   v = 8'h6C;
      4'd12:   v = 8'h65;
      4'd13:   v = 8'h00;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/vocoder_link_response_deframer_unit.sv]
// Vocoder link response deframer: takes one received byte per cycle, sustained, and returns
// at most one result item per byte (audio/voice payload bytes with index and last mark, or one
// kind result per control frame). A byte is registered in the input register and then in
// the result register; the byte parse between them is combinational, and a new byte is taken
// while a finished result waits, so throughput is limited only by out_ready.
module vocoder_link_response_deframer_unit #(
  parameter int unsigned AUDIO_PAYLOAD_BYTES = vlrd_pkg::AUDIO_PAYLOAD_BYTES_DEF,
  parameter int unsigned VOICE_PAYLOAD_BYTES = vlrd_pkg::VOICE_PAYLOAD_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_frame_kind,
  output logic [7:0] out_payload_byte,
  output logic [8:0] out_payload_index,
  output logic       out_frame_last
);

  logic              byte_valid;
  logic [7:0]        byte_data;
  logic              step;
  logic              res_valid;
  vlrd_pkg::result_t res;

  assign step = byte_valid && (!out_valid || out_ready);

  vlrd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .step       (step),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  vlrd_parser #(
    .AUDIO_PAYLOAD_BYTES (AUDIO_PAYLOAD_BYTES),
    .VOICE_PAYLOAD_BYTES (VOICE_PAYLOAD_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (byte_data),
    .res_valid (res_valid),
    .res       (res)
  );

  vlrd_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .step              (step),
    .res_valid         (res_valid),
    .res               (res),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_kind    (out_frame_kind),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_frame_last    (out_frame_last)
  );

endmodule

[hw/rtl/vlrd_in_stage.sv]
// Input register: holds one received byte until the parser takes it.
module vlrd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       step,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic [7:0] data_r;

  assign in_ready   = !valid_r || step;
  assign byte_valid = valid_r;
  assign byte_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (step) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_rx_byte;
    end
  end

endmodule

[hw/rtl/vlrd_parser.sv]
// Frame parser: header classification, payload counting and reply pattern checks.
module vlrd_parser #(
  parameter int unsigned AUDIO_PAYLOAD_BYTES = vlrd_pkg::AUDIO_PAYLOAD_BYTES_DEF,
  parameter int unsigned VOICE_PAYLOAD_BYTES = vlrd_pkg::VOICE_PAYLOAD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  output vlrd_pkg::result_t res
);

  localparam logic [9:0] AUDIO_TOTAL = 10'(AUDIO_PAYLOAD_BYTES);
  localparam logic [9:0] VOICE_TOTAL = 10'(VOICE_PAYLOAD_BYTES);
  localparam logic [8:0] STSP_FINAL  = 9'(vlrd_pkg::STSP_LEN - 1);
  localparam logic [8:0] NAME_FINAL  = 9'(vlrd_pkg::NAME_LEN - 1);
  localparam logic [8:0] NAME_END    = 9'(vlrd_pkg::NAME_LEN);
  localparam logic [8:0] BODY_START  = 9'd2;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_STSP    = 3'd3,
    PH_NAME    = 3'd4
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] hdr_r, hdr_nxt;
  logic       voice_r, voice_nxt;     // payload frame in progress is coded voice
  logic [8:0] cnt_r, cnt_nxt;
  logic       miss_r, miss_nxt;       // a compared reply byte differed

  logic [9:0] total;
  logic [9:0] idx_inc;
  logic       pay_last;
  logic       name_miss;

  assign total    = voice_r ? VOICE_TOTAL : AUDIO_TOTAL;
  assign idx_inc  = {1'b0, cnt_r} + 10'd1;
  assign pay_last = idx_inc >= total;
  assign name_miss = (cnt_r >= NAME_END) || (rx_byte != vlrd_pkg::name_pat(cnt_r[3:0]));

  always_comb begin
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    voice_nxt = voice_r;
    cnt_nxt   = cnt_r;
    miss_nxt  = miss_r;
    res_valid = 1'b0;
    res.kind  = vlrd_pkg::KIND_AUDIO;
    res.data  = 8'd0;
    res.index = 9'd0;
    res.last  = 1'b0;

    unique case (phase_r)
      PH_SECOND: begin
        if (hdr_r == vlrd_pkg::HDR_AUDIO_0 && rx_byte == vlrd_pkg::HDR_AUDIO_1) begin
          phase_nxt = PH_PAYLOAD;
          voice_nxt = 1'b0;
          cnt_nxt   = 9'd0;
        end else if (hdr_r == vlrd_pkg::HDR_VOICE_0 && rx_byte == vlrd_pkg::HDR_VOICE_1) begin
          phase_nxt = PH_PAYLOAD;
          voice_nxt = 1'b1;
          cnt_nxt   = 9'd0;
        end else if (hdr_r == vlrd_pkg::HDR_STSP_0 && rx_byte == vlrd_pkg::HDR_ZERO_1) begin
          phase_nxt = PH_STSP;
          cnt_nxt   = BODY_START;
          miss_nxt  = 1'b0;
        end else if (hdr_r == vlrd_pkg::HDR_NAME_0 && rx_byte == vlrd_pkg::HDR_ZERO_1) begin
          phase_nxt = PH_NAME;
          cnt_nxt   = BODY_START;
          miss_nxt  = 1'b0;
        end else begin
          phase_nxt = PH_FIRST;
          res_valid = 1'b1;
          res.last  = 1'b1;
          res.kind  = (hdr_r == vlrd_pkg::HDR_NOP_0 && rx_byte == vlrd_pkg::HDR_ZERO_1)
                      ? vlrd_pkg::KIND_NOP : vlrd_pkg::KIND_UNKNOWN;
        end
      end
      PH_PAYLOAD: begin
        res_valid = 1'b1;
        res.kind  = voice_r ? vlrd_pkg::KIND_VOICE : vlrd_pkg::KIND_AUDIO;
        res.data  = rx_byte;
        res.index = cnt_r;
        res.last  = pay_last;
        if (pay_last) begin
          phase_nxt = PH_FIRST;
          cnt_nxt   = 9'd0;
        end else begin
          cnt_nxt   = idx_inc[8:0];
        end
      end
      PH_STSP: begin
        if (cnt_r < STSP_FINAL) begin
          if (rx_byte != vlrd_pkg::stsp_pat(cnt_r[2:0])) begin
            miss_nxt = 1'b1;
          end
          cnt_nxt = idx_inc[8:0];
        end else begin
          phase_nxt = PH_FIRST;
          cnt_nxt   = 9'd0;
          miss_nxt  = 1'b0;
          res_valid = 1'b1;
          res.last  = 1'b1;
          if (!miss_r && rx_byte == vlrd_pkg::STSP_START) begin
            res.kind = vlrd_pkg::KIND_START;
          end else if (!miss_r && rx_byte == vlrd_pkg::STSP_STOP) begin
            res.kind = vlrd_pkg::KIND_STOP;
          end else begin
            res.kind = vlrd_pkg::KIND_ERROR;
          end
        end
      end
      PH_NAME: begin
        if (cnt_r < NAME_FINAL) begin
          miss_nxt = miss_r || name_miss;
          cnt_nxt  = idx_inc[8:0];
        end else begin
          phase_nxt = PH_FIRST;
          cnt_nxt   = 9'd0;
          miss_nxt  = 1'b0;
          res_valid = 1'b1;
          res.last  = 1'b1;
          res.kind  = (miss_r || name_miss) ? vlrd_pkg::KIND_ERROR : vlrd_pkg::KIND_NAME;
        end
      end
      default: begin
        // first header byte; a lone A0 or 81 resyncs straight into a payload
        if (rx_byte == vlrd_pkg::HDR_VOICE_1) begin
          phase_nxt = PH_PAYLOAD;
          voice_nxt = 1'b1;
          cnt_nxt   = 9'd0;
        end else if (rx_byte == vlrd_pkg::HDR_AUDIO_1) begin
          phase_nxt = PH_PAYLOAD;
          voice_nxt = 1'b0;
          cnt_nxt   = 9'd0;
        end else begin
          hdr_nxt   = rx_byte;
          phase_nxt = PH_SECOND;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      hdr_r   <= 8'd0;
      voice_r <= 1'b0;
      cnt_r   <= 9'd0;
      miss_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      voice_r <= voice_nxt;
      cnt_r   <= cnt_nxt;
      miss_r  <= miss_nxt;
    end
  end

endmodule

[hw/rtl/vlrd_out_stage.sv]
// Result register: holds one result item until the consumer takes it.
module vlrd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              res_valid,
  input  vlrd_pkg::result_t res,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_frame_kind,
  output logic [7:0]        out_payload_byte,
  output logic [8:0]        out_payload_index,
  output logic              out_frame_last
);

  logic              valid_r;
  vlrd_pkg::result_t res_r;

  assign out_valid         = valid_r;
  assign out_frame_kind    = res_r.kind;
  assign out_payload_byte  = res_r.data;
  assign out_payload_index = res_r.index;
  assign out_frame_last    = res_r.last;

  // step only fires when this register is empty or being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (step) begin
      valid_r <= res_valid;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      res_r <= res;
    end
  end

endmodule

[hw/rtl/vlrd_checker.sv]
// Port-level checks for the deframer, bound to the top level.
module vlrd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_frame_kind,
  input logic [7:0] out_payload_byte,
  input logic [8:0] out_payload_index,
  input logic       out_frame_last
);

  logic ctrl_kind;
  assign ctrl_kind = (out_frame_kind != vlrd_pkg::KIND_AUDIO) &&
                     (out_frame_kind != vlrd_pkg::KIND_VOICE);

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // control frames close with a single result
  a_ctrl_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ctrl_kind |-> out_frame_last)
    else $error("control result without last mark");

  a_ctrl_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ctrl_kind |-> out_payload_byte == 8'd0 && out_payload_index == 9'd0)
    else $error("control result with payload data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_kind) &&
    $stable(out_payload_byte) && $stable(out_payload_index) && $stable(out_frame_last))
    else $error("stalled result changed");

endmodule

bind vocoder_link_response_deframer_unit vlrd_checker u_vlrd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_frame_kind    (out_frame_kind),
  .out_payload_byte  (out_payload_byte),
  .out_payload_index (out_payload_index),
  .out_frame_last    (out_frame_last)
);
